/* rtl/filter_life_usage_meter_defines.svh */
// ----------------------------------------------------------------------------
// Filter life usage meter: assertion macros
// Clocked on clk, disabled while arst_n is low. Empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FILTER_LIFE_USAGE_METER_DEFINES_SVH
`define FILTER_LIFE_USAGE_METER_DEFINES_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define FLUM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// expression must never be true out of reset
`define FLUM_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define FLUM_ASSERT(lbl, prop, msg)
`define FLUM_NEVER(lbl, expr, msg)
`endif

`endif

/* rtl/flum_pkg.sv */
// ----------------------------------------------------------------------------
// Filter life usage meter: package
// Codes, fixed widths and shared types of the meter and its percent divider.
// ----------------------------------------------------------------------------
package flum_pkg;

	localparam int USAGE_W = 32;
	localparam int AIR_W   = 16;
	localparam int PCT_W   = 7;
	// usage * 100 needs seven more bits than the usage total
	localparam int PROD_W  = USAGE_W + PCT_W;
	localparam int CNT_W   = $clog2(PROD_W + 1);

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	localparam logic [15:0] SPEED_EDGE_ONE   = 16'd400;
	localparam logic [15:0] SPEED_EDGE_TWO   = 16'd800;
	localparam logic [15:0] SPEED_EDGE_THREE = 16'd1200;

	typedef enum logic [2:0] {
		MODE_SAMPLE = 3'd0,
		MODE_TICK   = 3'd1,
		MODE_RESET  = 3'd2,
		MODE_EXPIRE = 3'd3,
		MODE_LOAD   = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		REG_AIR_STOP  = 3'd0,
		REG_AIR_ONE   = 3'd1,
		REG_AIR_TWO   = 3'd2,
		REG_AIR_THREE = 3'd3,
		REG_AIR_FOUR  = 3'd4,
		REG_LIFE_PRE  = 3'd5,
		REG_LIFE_SEC  = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		STATUS_GOOD    = 2'd0,
		STATUS_WARN    = 2'd1,
		STATUS_REPLACE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RUN,
		ST_HOLD
	} flum_state_t;

	// divider status towards the control logic
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* rtl/flum_pct_div.sv */
// ----------------------------------------------------------------------------
// Filter life usage meter: percent divider
// Bit-serial restoring division of usage * 100 by the lifespan, one quotient
// bit per cycle, with the zero-lifespan and worn-out cases settled at start.
// ----------------------------------------------------------------------------
module flum_pct_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [flum_pkg::USAGE_W-1:0]          usage,
	input  logic [flum_pkg::USAGE_W-1:0]          life,
	output logic [flum_pkg::PCT_W-1:0]            pct,
	output flum_pkg::div_stat_t                   stat
);
	import flum_pkg::*;

	logic [PROD_W-1:0]  num_q;
	logic [USAGE_W-1:0] rem_q;
	logic [USAGE_W-1:0] life_q;
	logic [PCT_W-1:0]   quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic               zero_q;
	logic               full_q;

	logic [PROD_W-1:0]  prod;
	logic [USAGE_W:0]   trial;
	logic [USAGE_W+1:0] diff;
	logic               ge;

	// usage * 100 as three shifted copies: 64 + 32 + 4
	always_comb begin
		prod = (PROD_W'(usage) << 6) + (PROD_W'(usage) << 5) + (PROD_W'(usage) << 2);
	end

	// one restoring step: bring down the next numerator bit, try a subtract
	always_comb begin
		trial = {rem_q, num_q[PROD_W-1]};
		diff  = {1'b0, trial} - {2'b00, life_q};
		ge    = ~diff[USAGE_W+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: numerator shifts out MSB first, quotient shifts in
	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= prod;
			rem_q  <= '0;
			quo_q  <= '0;
			life_q <= life;
			zero_q <= (life == '0);
			full_q <= (usage >= life);
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? diff[USAGE_W-1:0] : trial[USAGE_W-1:0];
			quo_q <= {quo_q[PCT_W-2:0], ge};
		end
	end

	// below the lifespan the quotient is under 100 and fits seven bits
	always_comb begin
		if (zero_q)
			pct = '0;
		else if (full_q)
			pct = PCT_FULL;
		else
			pct = quo_q;
		stat.busy = busy_q;
		stat.done = done_q;
	end

endmodule

/* rtl/filter_life_usage_meter.sv */
// ----------------------------------------------------------------------------
// Filter life usage meter
// Tracks airflow wear on a pre filter and a second filter and reports the
// percent of life used, a status and a save request for every transaction.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------
//   in      | in_valid / in_stall  | mode, rpm, filter_sel, usage_value
//   out     | out_valid / out_stall| pre/second_percent, pre/second_status,
//           |                      | save_due
//   cfg     | cfg_we               | cfg_index, cfg_wdata
//
// Totals are updated at the accepting edge. The item then passes through the
// states LOAD (the dividers load), RUN (bit-serial divide steps over the
// 39-bit usage * 100 product, until both dividers are done) and HOLD (hand
// over to the output register, waiting while it is full and stalled). The
// next item is accepted once the result is in the output register, even if
// it is still stalled. No clearing pass after reset.
//
`include "filter_life_usage_meter_defines.svh"

module filter_life_usage_meter #(
	parameter int SAVE_INTERVAL    = 20,
	parameter int ALARM_PCT_PRE    = 80,
	parameter int ALARM_PCT_SECOND = 80
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [2:0]                        cfg_index,
	input  logic [flum_pkg::USAGE_W-1:0]      cfg_wdata,
	// input transactions
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        mode,
	input  logic [15:0]                       rpm,
	input  logic                              filter_sel,
	input  logic [flum_pkg::USAGE_W-1:0]      usage_value,
	// result transactions
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [flum_pkg::PCT_W-1:0]        pre_percent,
	output logic [flum_pkg::PCT_W-1:0]        second_percent,
	output logic [1:0]                        pre_status,
	output logic [1:0]                        second_status,
	output logic                              save_due
);
	import flum_pkg::*;

	localparam logic [7:0]       SAVE_RELOAD = 8'(SAVE_INTERVAL);
	localparam logic [PCT_W-1:0] ALARM_PRE   = PCT_W'(ALARM_PCT_PRE);
	localparam logic [PCT_W-1:0] ALARM_SEC   = PCT_W'(ALARM_PCT_SECOND);

	function automatic status_t status_of(input logic [PCT_W-1:0] pct,
	                                      input logic [PCT_W-1:0] alarm);
		if (pct >= PCT_FULL)
			return STATUS_REPLACE;
		else if (pct >= alarm)
			return STATUS_WARN;
		else
			return STATUS_GOOD;
	endfunction

	flum_state_t        state_q, state_d;
	logic [AIR_W-1:0]   airflow_q [5];
	logic [USAGE_W-1:0] life_q [2];
	logic [USAGE_W-1:0] total_q [2];
	logic [USAGE_W-1:0] total_d [2];
	logic [7:0]         count_q, count_d;
	logic               save_q, save_d;
	logic               out_valid_q;
	logic [PCT_W-1:0]   pre_pct_q, sec_pct_q;
	status_t            pre_status_q, sec_status_q;
	logic               save_due_q;

	logic               in_accept;
	logic               out_load;
	logic               div_start;
	logic [2:0]         speed;
	logic [AIR_W-1:0]   air_amt;
	logic [USAGE_W:0]   sum [2];
	logic [PCT_W-1:0]   pre_pct, sec_pct;
	div_stat_t          pre_stat, sec_stat;

	assign in_accept = in_valid & ~in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++)
				airflow_q[i] <= '0;
			life_q[0] <= '0;
			life_q[1] <= '0;
		end else if (cfg_we) begin
			case (cfg_index) inside
				[REG_AIR_STOP:REG_AIR_FOUR]: airflow_q[cfg_index] <= cfg_wdata[AIR_W-1:0];
				REG_LIFE_PRE:                life_q[0] <= cfg_wdata;
				REG_LIFE_SEC:                life_q[1] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// fan speed bucket
	always_comb begin
		if (rpm == 16'd0)
			speed = 3'd0;
		else if (rpm <= SPEED_EDGE_ONE)
			speed = 3'd1;
		else if (rpm <= SPEED_EDGE_TWO)
			speed = 3'd2;
		else if (rpm <= SPEED_EDGE_THREE)
			speed = 3'd3;
		else
			speed = 3'd4;
		air_amt = airflow_q[speed];
	end

	// next totals, countdown and save flag for the accepted transaction
	always_comb begin
		total_d = total_q;
		count_d = count_q;
		save_d  = 1'b0;
		for (int f = 0; f < 2; f++)
			sum[f] = {1'b0, total_q[f]} + (USAGE_W+1)'(air_amt);
		case (mode_t'(mode))
			MODE_SAMPLE: begin
				for (int f = 0; f < 2; f++) begin
					if (total_q[f] < life_q[f]) begin
						if (sum[f] > {1'b0, life_q[f]})
							total_d[f] = life_q[f];
						else
							total_d[f] = sum[f][USAGE_W-1:0];
					end
				end
			end
			MODE_TICK: begin
				if (count_q != 8'd0) begin
					count_d = count_q - 8'd1;
					if (count_q == 8'd1) begin
						save_d  = 1'b1;
						count_d = SAVE_RELOAD;
					end
				end
			end
			MODE_RESET: begin
				total_d[filter_sel] = '0;
				save_d = 1'b1;
			end
			MODE_EXPIRE: begin
				total_d[filter_sel] = life_q[filter_sel];
				save_d = 1'b1;
			end
			MODE_LOAD: begin
				total_d[filter_sel] = usage_value;
				save_d = 1'b1;
			end
			default: ;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			total_q[0] <= '0;
			total_q[1] <= '0;
			count_q    <= SAVE_RELOAD;
			save_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_accept) begin
				total_q <= total_d;
				count_q <= count_d;
				save_q  <= save_d;
			end
		end
	end

	// percent dividers, one per filter, run in lockstep
	flum_pct_div u_div_pre (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.usage  (total_q[0]),
		.life   (life_q[0]),
		.pct    (pre_pct),
		.stat   (pre_stat)
	);

	flum_pct_div u_div_sec (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.usage  (total_q[1]),
		.life   (life_q[1]),
		.pct    (sec_pct),
		.stat   (sec_stat)
	);

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_RUN;
			ST_RUN:  if (pre_stat.done && sec_stat.done) state_d = ST_HOLD;
			ST_HOLD: if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		div_start = (state_q == ST_LOAD);
		out_load  = (state_q == ST_HOLD) && (!out_valid_q || !out_stall);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pre_pct_q    <= pre_pct;
			sec_pct_q    <= sec_pct;
			pre_status_q <= status_of(pre_pct, ALARM_PRE);
			sec_status_q <= status_of(sec_pct, ALARM_SEC);
			save_due_q   <= save_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign pre_percent    = pre_pct_q;
	assign second_percent = sec_pct_q;
	assign pre_status     = pre_status_q;
	assign second_status  = sec_status_q;
	assign save_due       = save_due_q;

	// checks
	`FLUM_ASSERT(a_accept_loads, in_accept |=> state_q == ST_LOAD, "accepted item did not start")
	`FLUM_NEVER(a_idle_busy, state_q == ST_IDLE && (pre_stat.busy || sec_stat.busy), "divider busy in idle")
	`FLUM_NEVER(a_count_zero, count_q == 8'd0, "save countdown reached zero")
	`FLUM_ASSERT(a_pct_range, out_valid_q |-> (pre_pct_q <= PCT_FULL && sec_pct_q <= PCT_FULL), "percent above full")
	`FLUM_ASSERT(a_replace_full, out_valid_q |-> ((pre_status_q == STATUS_REPLACE) == (pre_pct_q == PCT_FULL)), "pre status does not match percent")

endmodule

/* tb/tb_filter_life_usage_meter.sv */
// ----------------------------------------------------------------------------
// Filter life usage meter: testbench
// Drives usage samples, minute ticks and filter reset/expire/load commands
// through the valid/stall input channel under several register settings.
// Every result is checked per field against pinned values in some directed
// rows, else an in-bench model of the two usage totals, the save countdown
// and percent/status arithmetic. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_filter_life_usage_meter;
	import flum_pkg::*;

	localparam int SAVE_EVERY    = 20;
	localparam int ALARM_PRE     = 80;
	localparam int ALARM_SEC     = 80;
	localparam int IDLE_PCT      = 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 60;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 300;
	localparam int SETUP_AT      = 4;
	localparam int CYCLE_LIMIT   = 1000000;

	typedef struct packed {
		mode_t       md;
		logic [15:0] rpm;
		logic        sel;
		logic [31:0] val;
	} command_t;

	typedef struct packed {
		logic [6:0] pre_pct;
		logic [6:0] sec_pct;
		status_t    pre_st;
		status_t    sec_st;
		logic       save;
	} reading_t;

	typedef struct {
		command_t cmd;
		bit       typed;
		reading_t want;
	} dir_row_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_we      = 1'b0;
	logic [2:0]  cfg_index   = '0;
	logic [31:0] cfg_wdata   = '0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [2:0]  mode        = '0;
	logic [15:0] rpm         = '0;
	logic        filter_sel  = 1'b0;
	logic [31:0] usage_value = '0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [6:0]  pre_percent;
	logic [6:0]  second_percent;
	logic [1:0]  pre_status;
	logic [1:0]  second_status;
	logic        save_due;

	// model state and its copy of the registers
	logic [15:0] airflow [5];
	logic [31:0] life_lim [2];
	logic [31:0] usage_tot [2];
	logic [7:0]  save_cnt;

	reading_t wear_due [$];
	dir_row_t dir_rows [$];
	int       mismatches = 0;
	int       cycles     = 0;
	logic     idle_en    = 1'b1;
	int       hold_req   = 0;
	int       hold_ack   = 0;
	int       hold_left  = 0;

	filter_life_usage_meter #(
		.SAVE_INTERVAL   (SAVE_EVERY),
		.ALARM_PCT_PRE   (ALARM_PRE),
		.ALARM_PCT_SECOND(ALARM_SEC)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.rpm           (rpm),
		.filter_sel    (filter_sel),
		.usage_value   (usage_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pre_percent   (pre_percent),
		.second_percent(second_percent),
		.pre_status    (pre_status),
		.second_status (second_status),
		.save_due      (save_due)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Model
	// ------------------------------------------------------------------------

	// floor(total * 100 / life), capped at 100; zero life reads as 0
	function automatic logic [6:0] pct_used(input logic [31:0] tot, input logic [31:0] lim);
		logic [63:0] q;
		if (lim == 32'd0)
			return 7'd0;
		q = ({32'd0, tot} * 64'd100) / {32'd0, lim};
		if (q > 64'd100)
			q = 64'd100;
		return q[6:0];
	endfunction

	function automatic status_t wear_status(input logic [6:0] pct, input int alarm);
		if (pct >= 7'd100)
			return STATUS_REPLACE;
		if (pct >= alarm)
			return STATUS_WARN;
		return STATUS_GOOD;
	endfunction

	// add airflow to one total, stopping at the lifespan
	function automatic void add_wear(input int f, input logic [15:0] amount);
		logic [32:0] sum;
		if (usage_tot[f] >= life_lim[f])
			return;
		sum = {1'b0, usage_tot[f]} + {17'd0, amount};
		usage_tot[f] = (sum > {1'b0, life_lim[f]}) ? life_lim[f] : sum[31:0];
	endfunction

	// apply one command to the model and return the reading it produces
	function automatic reading_t predict_wear(input command_t c);
		reading_t r;
		int       speed;
		r.save = 1'b0;
		case (c.md)
			MODE_SAMPLE: begin
				if (c.rpm == 16'd0)
					speed = 0;
				else if (c.rpm <= SPEED_EDGE_ONE)
					speed = 1;
				else if (c.rpm <= SPEED_EDGE_TWO)
					speed = 2;
				else if (c.rpm <= SPEED_EDGE_THREE)
					speed = 3;
				else
					speed = 4;
				add_wear(0, airflow[speed]);
				add_wear(1, airflow[speed]);
			end
			MODE_TICK: begin
				if (save_cnt != 8'd0) begin
					save_cnt = save_cnt - 8'd1;
					if (save_cnt == 8'd0) begin
						r.save   = 1'b1;
						save_cnt = SAVE_EVERY[7:0];
					end
				end
			end
			MODE_RESET: begin
				usage_tot[c.sel] = 32'd0;
				r.save           = 1'b1;
			end
			MODE_EXPIRE: begin
				usage_tot[c.sel] = life_lim[c.sel];
				r.save           = 1'b1;
			end
			MODE_LOAD: begin
				usage_tot[c.sel] = c.val;
				r.save           = 1'b1;
			end
			default: ;
		endcase
		r.pre_pct = pct_used(usage_tot[0], life_lim[0]);
		r.sec_pct = pct_used(usage_tot[1], life_lim[1]);
		r.pre_st  = wear_status(r.pre_pct, ALARM_PRE);
		r.sec_st  = wear_status(r.sec_pct, ALARM_SEC);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic dir_row_t via(input mode_t m, input logic [15:0] r, input logic s,
			input logic [31:0] v);
		dir_row_t d;
		d.cmd   = '{m, r, s, v};
		d.typed = 1'b0;
		d.want  = '0;
		return d;
	endfunction

	function automatic dir_row_t pinned(input mode_t m, input logic [15:0] r, input logic s,
			input logic [31:0] v, input logic [6:0] p0, input logic [6:0] p1,
			input status_t s0, input status_t s1, input logic sv);
		dir_row_t d;
		d.cmd   = '{m, r, s, v};
		d.typed = 1'b1;
		d.want  = '{p0, p1, s0, s1, sv};
		return d;
	endfunction

	// rpm on or next to a speed boundary, or at its maximum
	function automatic logic [15:0] edge_rpm();
		case ($urandom_range(8))
			0: return 16'd0;
			1: return 16'd1;
			2: return SPEED_EDGE_ONE;
			3: return SPEED_EDGE_ONE + 16'd1;
			4: return SPEED_EDGE_TWO;
			5: return SPEED_EDGE_TWO + 16'd1;
			6: return SPEED_EDGE_THREE;
			7: return SPEED_EDGE_THREE + 16'd1;
			default: return 16'hFFFF;
		endcase
	endfunction

	// mostly samples and ticks, with filter commands mixed in
	function automatic command_t random_command();
		command_t c;
		int       k;
		k     = $urandom_range(99);
		c.sel = 1'($urandom_range(1));
		if (k < 55)
			c.md = MODE_SAMPLE;
		else if (k < 75)
			c.md = MODE_TICK;
		else if (k < 83)
			c.md = MODE_RESET;
		else if (k < 90)
			c.md = MODE_EXPIRE;
		else
			c.md = MODE_LOAD;
		case ($urandom_range(3))
			0: c.rpm = edge_rpm();
			1: c.rpm = 16'($urandom_range(65535));
			default: c.rpm = 16'($urandom_range(1500));
		endcase
		case ($urandom_range(2))
			0: c.val = $urandom();
			1: c.val = life_lim[c.sel] + $urandom_range(16) - 32'd8;
			default: c.val = (life_lim[c.sel] == 32'd0) ? $urandom() :
				$urandom_range(life_lim[c.sel]);
		endcase
		return c;
	endfunction

	// offer one transaction and record its expected reading on acceptance
	task automatic send_command(input command_t c, input bit typed, input reading_t want);
		reading_t r;
		while (idle_en && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= c.md;
		rpm         <= c.rpm;
		filter_sel  <= c.sel;
		usage_value <= c.val;
		do
			@(posedge clk);
		while (in_stall);
		r = predict_wear(c);
		wear_due.push_back(typed ? want : r);
	endtask

	// stop offering and wait until every expected reading has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (wear_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_LIFE_PRE: life_lim[0] = val;
			REG_LIFE_SEC: life_lim[1] = val;
			default:      airflow[idx] = val[15:0];
		endcase
	endtask

	task automatic load_setup(input logic [4:0][15:0] air, input logic [31:0] lp,
			input logic [31:0] ls);
		for (int k = 0; k < 5; k++)
			write_reg(reg_idx_t'(k), {16'd0, air[k]});
		write_reg(REG_LIFE_PRE, lp);
		write_reg(REG_LIFE_SEC, ls);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off on request
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// ------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------
	function automatic int field_err(input string name, input int exp_v, input int act_v);
		if (exp_v == act_v)
			return 0;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
		return 1;
	endfunction

	always @(posedge clk) begin : check_results
		reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (wear_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result transaction, expected none, actual %0d/%0d",
					$realtime, pre_percent, second_percent);
			end else begin
				want = wear_due.pop_front();
				mismatches += field_err("pre_percent", want.pre_pct, pre_percent);
				mismatches += field_err("second_percent", want.sec_pct, second_percent);
				mismatches += field_err("pre_status", want.pre_st, pre_status);
				mismatches += field_err("second_status", want.sec_st, second_status);
				mismatches += field_err("save_due", want.save, save_due);
			end
		end
	end

	// run-away guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : main_seq
		logic [4:0][15:0] air;
		logic [31:0]      lp;
		logic [31:0]      ls;

		foreach (airflow[k])
			airflow[k] = 16'd0;
		life_lim[0]  = 32'd0;
		life_lim[1]  = 32'd0;
		usage_tot[0] = 32'd0;
		usage_tot[1] = 32'd0;
		save_cnt     = SAVE_EVERY[7:0];

		// with every register at zero nothing can wear
		dir_rows.push_back(pinned(MODE_TICK, 16'd0, 1'b0, 32'd0, 7'd0, 7'd0,
			STATUS_GOOD, STATUS_GOOD, 1'b0));
		dir_rows.push_back(pinned(MODE_SAMPLE, 16'hFFFF, 1'b0, 32'd0, 7'd0, 7'd0,
			STATUS_GOOD, STATUS_GOOD, 1'b0));
		dir_rows.push_back(pinned(MODE_LOAD, 16'd0, 1'b0, 32'hFFFF_FFFF, 7'd0, 7'd0,
			STATUS_GOOD, STATUS_GOOD, 1'b1));
		dir_rows.push_back(pinned(MODE_EXPIRE, 16'd0, 1'b1, 32'd0, 7'd0, 7'd0,
			STATUS_GOOD, STATUS_GOOD, 1'b1));
		// pre life 1000, second life at maximum; walk every speed boundary
		dir_rows.push_back(pinned(MODE_RESET, 16'd0, 1'b0, 32'd0, 7'd0, 7'd0,
			STATUS_GOOD, STATUS_GOOD, 1'b1));
		dir_rows.push_back(via(MODE_SAMPLE, 16'd0, 1'b0, 32'd0));
		dir_rows.push_back(via(MODE_SAMPLE, 16'd1, 1'b1, 32'd0));
		dir_rows.push_back(via(MODE_SAMPLE, 16'd400, 1'b0, 32'd0));
		dir_rows.push_back(via(MODE_SAMPLE, 16'd401, 1'b0, 32'd0));
		dir_rows.push_back(via(MODE_SAMPLE, 16'd800, 1'b0, 32'd0));
		dir_rows.push_back(pinned(MODE_SAMPLE, 16'd801, 1'b0, 32'd0, 7'd100, 7'd0,
			STATUS_REPLACE, STATUS_GOOD, 1'b0));
		dir_rows.push_back(via(MODE_SAMPLE, 16'd1200, 1'b0, 32'd0));
		dir_rows.push_back(via(MODE_SAMPLE, 16'd1201, 1'b0, 32'd0));
		dir_rows.push_back(via(MODE_SAMPLE, 16'hFFFF, 1'b1, 32'hFFFF_FFFF));
		// alarm threshold and full-scale loads
		dir_rows.push_back(pinned(MODE_LOAD, 16'd0, 1'b0, 32'd800, 7'd80, 7'd0,
			STATUS_WARN, STATUS_GOOD, 1'b1));
		dir_rows.push_back(via(MODE_LOAD, 16'd0, 1'b0, 32'd799));
		dir_rows.push_back(pinned(MODE_LOAD, 16'd0, 1'b1, 32'hFFFF_FFFF, 7'd79, 7'd100,
			STATUS_GOOD, STATUS_REPLACE, 1'b1));
		dir_rows.push_back(via(MODE_LOAD, 16'd0, 1'b1, 32'hFFFF_FFFE));
		dir_rows.push_back(via(MODE_EXPIRE, 16'd0, 1'b0, 32'd0));
		dir_rows.push_back(via(MODE_RESET, 16'd0, 1'b1, 32'd0));
		// total above life: capped percent, no further wear
		dir_rows.push_back(via(MODE_LOAD, 16'd0, 1'b0, 32'hFFFF_FFFF));
		dir_rows.push_back(via(MODE_SAMPLE, 16'h8000, 1'b0, 32'd0));
		dir_rows.push_back(via(MODE_TICK, 16'd0, 1'b0, 32'd0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed transactions
		foreach (dir_rows[i]) begin
			if (i == SETUP_AT) begin
				drain_results();
				load_setup({16'd65535, 16'd1000, 16'd250, 16'd100, 16'd5},
					32'd1000, 32'hFFFF_FFFF);
			end
			send_command(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);
		end

		// random phases, each under its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			idle_en <= (ph != 1);
			for (int k = 0; k < 5; k++)
				air[k] = 16'($urandom_range(2000));
			lp = $urandom_range(200000, 1000);
			ls = $urandom_range(200000, 1000);
			case (ph)
				1: begin
					air = {5{16'hFFFF}};
					lp  = 32'hFFFF_FFFF;
					ls  = 32'hFFFF_FFFF;
				end
				2: begin
					air[0] = 16'd0;
					air[2] = 16'd0;
					lp     = 32'd0;
					ls     = $urandom_range(5000, 1);
				end
				3: begin
					// lifespans lowered below the totals built up so far
					for (int k = 0; k < 5; k++)
						air[k] = 16'($urandom_range(50));
					lp = $urandom_range(300, 1);
					ls = $urandom_range(300, 1);
				end
				4: begin
					lp = 32'd1;
					ls = 32'hFFFF_FFFF;
				end
				5: begin
					for (int k = 0; k < 5; k++)
						air[k] = 16'($urandom_range(65535));
					lp = $urandom();
					ls = $urandom();
				end
				default: ;
			endcase
			load_setup(air, lp, ls);

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver hold-off while transactions keep coming
				if (n == 100 && (ph == 0 || ph == 4))
					hold_req <= hold_req + 1;
				// sender waits for the pipeline to empty mid-phase
				if (n == 150 && ph == 2)
					drain_results();
				send_command(random_command(), 1'b0, '0);
			end
		end

		drain_results();
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
